FILE: hw/rtl/tsp_pkg.sv
package tsp_pkg;

  // Field widths.
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CRUISE_W = 12;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned TMO_W    = 24;
  localparam int unsigned SPEED_W  = 22;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  // Product widths.
  localparam int unsigned PROD_E_W = TIME_W + RATE_W;
  localparam int unsigned PROD_T_W = TMO_W + RATE_W;

  // Milliseconds per second, the scale from mm/s to 0.001 mm/s.
  localparam logic [9:0] MS_PER_S = 10'd1000;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [CRUISE_W-1:0] CRUISE_RST  = 12'd500;
  localparam logic [RATE_W-1:0]   ACCEL_RST   = 16'd1000;
  localparam logic [RATE_W-1:0]   DECEL_RST   = 16'd1000;
  localparam logic [TMO_W-1:0]    TIMEOUT_RST = 24'd10000;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  // Sequencer stage payload.
  typedef struct packed {
    phase_t              phase;
    logic [TIME_W-1:0]   elapsed;
  } s1_t;

  // Product stage payload.
  typedef struct packed {
    phase_t              phase;
    logic [TIME_W-1:0]   elapsed;
    logic [PROD_E_W-1:0] ramp_prod;
    logic [PROD_E_W-1:0] brake_prod;
    logic [PROD_T_W-1:0] end_prod;
    logic [PROD_T_W-1:0] remain_prod;
    logic                past_end;
    logic [SPEED_W-1:0]  top_speed;
  } s2_t;

  // Result payload.
  typedef struct packed {
    phase_t              phase;
    logic [TIME_W-1:0]   elapsed;
    logic [SPEED_W-1:0]  speed;
  } res_t;

endpackage

FILE: hw/rtl/tsp_in_if.sv
interface tsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [tsp_pkg::KIND_W-1:0]  kind;
  logic [tsp_pkg::TIME_W-1:0]  now_time;

  modport source (output valid, output kind, output now_time, input ready);
  modport sink   (input valid, input kind, input now_time, output ready);
endinterface

FILE: hw/rtl/tsp_out_if.sv
interface tsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   phase_code;
  logic                         running_flag;
  logic                         line_follow;
  logic                         stopped_flag;
  logic [tsp_pkg::TIME_W-1:0]   elapsed_time;
  logic [tsp_pkg::SPEED_W-1:0]  base_speed;

  modport source (output valid, output phase_code, output running_flag,
                  output line_follow, output stopped_flag, output elapsed_time,
                  output base_speed, input ready);
  modport sink   (input valid, input phase_code, input running_flag,
                  input line_follow, input stopped_flag, input elapsed_time,
                  input base_speed, output ready);
endinterface

FILE: hw/rtl/tsp_seq.sv
module tsp_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tsp_pkg::KIND_W-1:0]   kind,
  input  logic [tsp_pkg::TIME_W-1:0]   now_time,
  input  logic [tsp_pkg::TMO_W-1:0]    run_timeout,
  output logic                         s1_valid,
  input  logic                         s1_ready,
  output tsp_pkg::s1_t                 s1
);

  tsp_pkg::phase_t             phase_r, phase_nxt;
  logic [tsp_pkg::TIME_W-1:0]  start_r, start_nxt;
  logic [tsp_pkg::TIME_W-1:0]  last_r, last_nxt;
  logic [tsp_pkg::TIME_W-1:0]  finish_r, finish_nxt;
  logic [tsp_pkg::TIME_W-1:0]  elapsed_nxt;
  logic [tsp_pkg::TIME_W-1:0]  tick_diff;
  logic [tsp_pkg::TIME_W-1:0]  tmo_ext;
  logic                        valid_r;
  tsp_pkg::s1_t                s1_r;
  logic                        accept;

  assign in_ready = !valid_r || s1_ready;
  assign accept   = in_valid && in_ready;
  assign tmo_ext  = {{(tsp_pkg::TIME_W - tsp_pkg::TMO_W){1'b0}}, run_timeout};
  assign tick_diff = now_time - start_r;

  // Next run state and the elapsed time reported for this item.
  always_comb begin
    phase_nxt   = phase_r;
    start_nxt   = start_r;
    last_nxt    = last_r;
    finish_nxt  = finish_r;
    elapsed_nxt = '0;
    case (kind)
      tsp_pkg::KIND_START: begin
        phase_nxt  = tsp_pkg::PH_RUN;
        start_nxt  = now_time;
        last_nxt   = now_time;
        finish_nxt = '0;
      end
      tsp_pkg::KIND_ABORT: begin
        phase_nxt  = tsp_pkg::PH_IDLE;
        start_nxt  = '0;
        last_nxt   = '0;
        finish_nxt = '0;
      end
      tsp_pkg::KIND_TICK: begin
        case (phase_r)
          tsp_pkg::PH_RUN: begin
            last_nxt = now_time;
            if (tick_diff >= tmo_ext) begin
              // Timeout reached: the finish stamp sits exactly one timeout on.
              phase_nxt   = tsp_pkg::PH_STOP;
              finish_nxt  = start_r + tmo_ext;
              elapsed_nxt = tmo_ext;
            end else begin
              elapsed_nxt = tick_diff;
            end
          end
          tsp_pkg::PH_STOP: elapsed_nxt = finish_r - start_r;
          default:          elapsed_nxt = '0;
        endcase
      end
      default: begin
        // Unused kind only reports the current state.
        case (phase_r)
          tsp_pkg::PH_RUN:  elapsed_nxt = last_r - start_r;
          tsp_pkg::PH_STOP: elapsed_nxt = finish_r - start_r;
          default:          elapsed_nxt = '0;
        endcase
      end
    endcase
  end

  // Run state and stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tsp_pkg::PH_IDLE;
      start_r  <= '0;
      last_r   <= '0;
      finish_r <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        start_r  <= start_nxt;
        last_r   <= last_nxt;
        finish_r <= finish_nxt;
      end
      if (in_ready) begin
        valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.phase   <= phase_nxt;
      s1_r.elapsed <= elapsed_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1       = s1_r;

endmodule

FILE: hw/rtl/tsp_mul.sv
module tsp_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  output logic                          s1_ready,
  input  tsp_pkg::s1_t                  s1,
  input  logic [tsp_pkg::CRUISE_W-1:0]  cruise_speed,
  input  logic [tsp_pkg::RATE_W-1:0]    accel_rate,
  input  logic [tsp_pkg::RATE_W-1:0]    decel_rate,
  input  logic [tsp_pkg::TMO_W-1:0]     run_timeout,
  output logic                          s2_valid,
  input  logic                          s2_ready,
  output tsp_pkg::s2_t                  s2
);

  logic                          valid_r;
  tsp_pkg::s2_t                  s2_r, s2_nxt;
  logic                          load;
  logic [tsp_pkg::TIME_W-1:0]    tmo_ext;
  logic [tsp_pkg::TMO_W-1:0]     remain;

  assign s1_ready = !valid_r || s2_ready;
  assign load     = s1_valid && s1_ready;
  assign tmo_ext  = {{(tsp_pkg::TIME_W - tsp_pkg::TMO_W){1'b0}}, run_timeout};
  // Only meaningful while the elapsed time is below the timeout.
  assign remain   = run_timeout - s1.elapsed[tsp_pkg::TMO_W-1:0];

  // Independent products for the ramp, cruise and braking tests.
  always_comb begin
    s2_nxt.phase       = s1.phase;
    s2_nxt.elapsed     = s1.elapsed;
    s2_nxt.ramp_prod   = {{(tsp_pkg::PROD_E_W - tsp_pkg::TIME_W){1'b0}}, s1.elapsed} *
                         {{(tsp_pkg::PROD_E_W - tsp_pkg::RATE_W){1'b0}}, accel_rate};
    s2_nxt.brake_prod  = {{(tsp_pkg::PROD_E_W - tsp_pkg::TIME_W){1'b0}}, s1.elapsed} *
                         {{(tsp_pkg::PROD_E_W - tsp_pkg::RATE_W){1'b0}}, decel_rate};
    s2_nxt.end_prod    = {{(tsp_pkg::PROD_T_W - tsp_pkg::TMO_W){1'b0}}, run_timeout} *
                         {{(tsp_pkg::PROD_T_W - tsp_pkg::RATE_W){1'b0}}, decel_rate};
    s2_nxt.remain_prod = {{(tsp_pkg::PROD_T_W - tsp_pkg::TMO_W){1'b0}}, remain} *
                         {{(tsp_pkg::PROD_T_W - tsp_pkg::RATE_W){1'b0}}, decel_rate};
    s2_nxt.past_end    = s1.elapsed >= tmo_ext;
    s2_nxt.top_speed   = {{(tsp_pkg::SPEED_W - tsp_pkg::CRUISE_W){1'b0}}, cruise_speed} *
                         {{(tsp_pkg::SPEED_W - $bits(tsp_pkg::MS_PER_S)){1'b0}},
                          tsp_pkg::MS_PER_S};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_ready) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = valid_r;
  assign s2       = s2_r;

endmodule

FILE: hw/rtl/tsp_sel.sv
module tsp_sel (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s2_valid,
  output logic          s2_ready,
  input  tsp_pkg::s2_t  s2,
  output logic          res_valid,
  input  logic          res_ready,
  output tsp_pkg::res_t res
);

  logic                             valid_r;
  tsp_pkg::res_t                    res_r;
  logic [tsp_pkg::SPEED_W-1:0]      speed_nxt;
  logic [tsp_pkg::PROD_E_W:0]       brake_sum;
  logic [tsp_pkg::PROD_E_W:0]       end_ext;
  logic [tsp_pkg::PROD_E_W-1:0]     top_e;
  logic [tsp_pkg::PROD_T_W-1:0]     top_t;
  logic                             load;

  assign s2_ready = !valid_r || res_ready;
  assign load     = s2_valid && s2_ready;

  assign top_e     = {{(tsp_pkg::PROD_E_W - tsp_pkg::SPEED_W){1'b0}}, s2.top_speed};
  assign top_t     = {{(tsp_pkg::PROD_T_W - tsp_pkg::SPEED_W){1'b0}}, s2.top_speed};
  assign brake_sum = {1'b0, s2.brake_prod} + {1'b0, top_e};
  assign end_ext   = {{(tsp_pkg::PROD_E_W + 1 - tsp_pkg::PROD_T_W){1'b0}}, s2.end_prod};

  // Trapezoid selection and clamp to the cruise speed.
  always_comb begin
    if (s2.phase != tsp_pkg::PH_RUN) begin
      speed_nxt = '0;
    end else if (s2.ramp_prod < top_e) begin
      speed_nxt = s2.ramp_prod[tsp_pkg::SPEED_W-1:0];
    end else if (brake_sum < end_ext) begin
      speed_nxt = s2.top_speed;
    end else if (s2.past_end) begin
      speed_nxt = '0;
    end else if (s2.remain_prod > top_t) begin
      speed_nxt = s2.top_speed;
    end else begin
      speed_nxt = s2.remain_prod[tsp_pkg::SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s2_ready) begin
      valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r.phase   <= s2.phase;
      res_r.elapsed <= s2.elapsed;
      res_r.speed   <= speed_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

FILE: hw/rtl/timed_trapezoid_speed_profile_unit.sv
// Channel  | Direction | Handshake      | Payload
// in_ch    | in        | valid / ready  | kind, now_time
// out_ch   | out       | valid / ready  | phase_code, running_flag, line_follow,
//          |           |                | stopped_flag, elapsed_time, base_speed
// cfg      | in        | cfg_we         | cfg_idx, cfg_wdata
//
// One item per cycle while out_ch does not stall. An item taken on in_ch
// passes through three register stages in order before it is on out_ch:
// run sequencer, product stage (five parallel multipliers) and the
// compare/clamp result stage.
// rst_n is synchronous and active low; it clears the run state and the
// configuration registers to their defaults. A stall on out_ch backs up
// stage by stage and removes in_ch.ready only once all three stages are full.
module timed_trapezoid_speed_profile_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  tsp_in_if.sink                          in_ch,
  tsp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [tsp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tsp_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  logic [tsp_pkg::CRUISE_W-1:0]  cruise_r;
  logic [tsp_pkg::RATE_W-1:0]    accel_r;
  logic [tsp_pkg::RATE_W-1:0]    decel_r;
  logic [tsp_pkg::TMO_W-1:0]     timeout_r;

  logic           s1_valid, s1_ready;
  logic           s2_valid, s2_ready;
  logic           res_valid;
  tsp_pkg::s1_t   s1;
  tsp_pkg::s2_t   s2;
  tsp_pkg::res_t  res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cruise_r  <= tsp_pkg::CRUISE_RST;
      accel_r   <= tsp_pkg::ACCEL_RST;
      decel_r   <= tsp_pkg::DECEL_RST;
      timeout_r <= tsp_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        tsp_pkg::REG_CRUISE:  cruise_r  <= cfg_wdata[tsp_pkg::CRUISE_W-1:0];
        tsp_pkg::REG_ACCEL:   accel_r   <= cfg_wdata[tsp_pkg::RATE_W-1:0];
        tsp_pkg::REG_DECEL:   decel_r   <= cfg_wdata[tsp_pkg::RATE_W-1:0];
        tsp_pkg::REG_TIMEOUT: timeout_r <= cfg_wdata[tsp_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  tsp_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .kind        (in_ch.kind),
    .now_time    (in_ch.now_time),
    .run_timeout (timeout_r),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1          (s1)
  );

  tsp_mul u_mul (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .s1           (s1),
    .cruise_speed (cruise_r),
    .accel_rate   (accel_r),
    .decel_rate   (decel_r),
    .run_timeout  (timeout_r),
    .s2_valid     (s2_valid),
    .s2_ready     (s2_ready),
    .s2           (s2)
  );

  tsp_sel u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2        (s2),
    .res_valid (res_valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  // Result fields; all three flags follow the phase.
  assign out_ch.valid        = res_valid;
  assign out_ch.phase_code   = res.phase;
  assign out_ch.running_flag = (res.phase == tsp_pkg::PH_RUN);
  assign out_ch.line_follow  = (res.phase == tsp_pkg::PH_RUN);
  assign out_ch.stopped_flag = (res.phase == tsp_pkg::PH_STOP);
  assign out_ch.elapsed_time = res.elapsed;
  assign out_ch.base_speed   = res.speed;

endmodule
